[src/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg: shared definitions for the ChaCha20 stream cipher
// Holds the state geometry, the sigma constants, the register map and the
// control and status bundles between the top level and the block generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

	localparam int unsigned WORDS      = 16;
	localparam int unsigned STEPS      = 80;   // 10 double rounds of 8 quarter rounds
	localparam int unsigned STEP_W     = 7;
	localparam int unsigned SLOTS      = 8;
	localparam int unsigned SLOT_W     = 3;
	localparam int unsigned REG_IDX_W  = 3;

	localparam logic [31:0] SIGMA [4] = '{
		32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
	};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY_0_7     = 3'd0,
		REG_KEY_8_15    = 3'd1,
		REG_KEY_16_23   = 3'd2,
		REG_KEY_24_31   = 3'd3,
		REG_NONCE_0_7   = 3'd4,
		REG_NONCE_8_11  = 3'd5,
		REG_INIT_COUNT  = 3'd6
	} cfg_reg_t;

	typedef logic [3:0][63:0] key_t;

	typedef struct packed {
		logic        start;
		logic [31:0] block_count;
	} gen_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

endpackage

`default_nettype wire

[src/cc20_block_gen.sv]
// ----------------------------------------------------------------------------
// cc20_block_gen: iterative ChaCha20 keystream block generator
// One quarter-round unit works on column 0 of the 4x4 state each cycle; the
// rows are rotated after every step so that all columns and diagonals pass
// through it. A final add state adds the initial state back in.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_block_gen (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cc20_pkg::gen_ctrl_t      ctrl,
	input  wire cc20_pkg::key_t           key,
	input  wire logic [95:0]              nonce,
	input  wire logic [2:0]               slot,
	output cc20_pkg::gen_stat_t           stat,
	output logic [63:0]                   ks_word
);
	import cc20_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_ROUND = 3'b010,
		C_ADD   = 3'b100
	} gen_state_t;

	gen_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0]       count_q;
	logic [31:0]       w_q    [WORDS];
	logic [31:0]       init_w [WORDS];
	logic [31:0]       mix_w  [WORDS];
	logic [31:0]       step_w [WORDS];
	logic [1:0]        amt    [4];
	logic [31:0]       cnt_sel;
	logic              last_step;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	assign cnt_sel   = (state_q == C_IDLE) ? ctrl.block_count : count_q;
	assign last_step = (step_q == STEP_W'(STEPS - 1));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key[i][31:0];
			init_w[5 + 2 * i] = key[i][63:32];
		end
		init_w[12] = cnt_sel;
		init_w[13] = nonce[31:0];
		init_w[14] = nonce[63:32];
		init_w[15] = nonce[95:64];
	end

	// quarter round on column 0
	always_comb begin
		logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
		a1 = w_q[0] + w_q[4];
		d1 = rol32(w_q[12] ^ a1, 16);
		c1 = w_q[8] + d1;
		b1 = rol32(w_q[4] ^ c1, 12);
		a2 = a1 + b1;
		d2 = rol32(d1 ^ a2, 8);
		c2 = c1 + d2;
		b2 = rol32(b1 ^ c2, 7);
		for (int i = 0; i < WORDS; i++) begin
			mix_w[i] = w_q[i];
		end
		mix_w[0]  = a2;
		mix_w[4]  = b2;
		mix_w[8]  = c2;
		mix_w[12] = d2;
	end

	// row rotation: one column per step, plus diagonalise after the column
	// round and undo it after the diagonal round
	always_comb begin
		logic [1:0] col;
		for (int r = 0; r < 4; r++) begin
			if (step_q[2:0] == 3'd3) begin
				amt[r] = 2'(1 + r);
			end else if (step_q[2:0] == 3'd7) begin
				amt[r] = 2'(1 - r);
			end else begin
				amt[r] = 2'd1;
			end
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				col = 2'(c) + amt[r];
				step_w[4 * r + c] = mix_w[{2'(r), col}];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctrl.start) begin
						count_q <= ctrl.block_count;
						step_q  <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					step_q <= step_q + STEP_W'(1);
					if (last_step) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WORDS; i++) begin
			if (state_q == C_IDLE && ctrl.start) begin
				w_q[i] <= init_w[i];
			end else if (state_q == C_ROUND) begin
				w_q[i] <= step_w[i];
			end else if (state_q == C_ADD) begin
				w_q[i] <= w_q[i] + init_w[i];
			end
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = (state_q == C_ADD);
	assign ks_word   = {w_q[{slot, 1'b1}], w_q[{slot, 1'b0}]};

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == C_IDLE)
		else $error("block start while generator busy");
	a_add_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ADD |-> $past(state_q == C_ROUND) && $past(step_q) == STEP_W'(STEPS - 1))
		else $error("final add not preceded by last round step");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ROUND |-> step_q < STEP_W'(STEPS))
		else $error("round step counter out of range");
`endif

endmodule

`default_nettype wire

[src/chacha20_stream_cipher.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_cipher: ChaCha20 (20 rounds) encrypt/decrypt, 64-bit words
// Input beats carry text_word, valid_bytes, first_word and final_word and are
// taken when in_valid is high and in_stall is low. Output beats carry
// result_word, result_bytes and end_of_message under out_valid/out_stall.
// Key, nonce and initial block count are loaded through cfg_we, cfg_index and
// cfg_data; the user must load them only while no beat is in flight, as the
// block does not enforce this. Writes to unknown indexes drop. A first_word
// beat reloads the block count and restarts at slot 0. A beat landing on
// slot 0 builds a keystream block: the round steps run through the shared
// quarter-round unit, then the initial state is added. out_valid rises and
// in_stall drops together once the result is registered. Other beats reuse
// the stored block and skip the build. The quarter-round loop sets the cost
// of each 64-byte block (8 beats). One beat is in work at a time.
// arst_n clears the key and nonce, sets the initial count to 1, and sets
// block count and slot to 0; with no first word the stream starts at block 0.
// A result waits in the output register while out_stall is high; the next
// beat may be taken meanwhile and waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [cc20_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] text_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        first_word,
	input  wire logic        final_word,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      result_word,
	output logic [3:0]       result_bytes,
	output logic             end_of_message
);
	import cc20_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_BUILD = 3'b010,
		S_WAIT  = 3'b100
	} top_state_t;

	top_state_t        state_q;

	// configuration registers
	key_t              key_q;
	logic [63:0]       nonce_lo_q;
	logic [31:0]       nonce_hi_q;
	logic [31:0]       init_count_q;

	// stream position
	logic [31:0]       block_q;
	logic [SLOT_W-1:0] slot_q;

	// beat in work
	logic [63:0]       item_text_q;
	logic [3:0]        item_count_q;
	logic              item_final_q;
	logic [SLOT_W-1:0] item_slot_q;

	// output register
	logic              out_valid_q;
	logic [63:0]       out_word_q;
	logic [3:0]        out_bytes_q;
	logic              out_end_q;

	logic              accept;
	logic [SLOT_W-1:0] slot_use;
	logic [31:0]       block_use;
	logic              need_block;
	logic              out_free;
	logic              load_out;
	logic [63:0]       ks_word;
	logic [63:0]       byte_mask;
	gen_ctrl_t         gen_ctrl;
	gen_stat_t         gen_stat;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign slot_use   = first_word ? '0 : slot_q;
	assign block_use  = first_word ? init_count_q : block_q;
	assign need_block = (slot_use == '0);
	assign out_free   = !out_valid_q || !out_stall;
	assign load_out   = (state_q == S_WAIT) && out_free;

	assign gen_ctrl.start       = accept && need_block;
	assign gen_ctrl.block_count = block_use;

	cc20_block_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (gen_ctrl),
		.key     (key_q),
		.nonce   ({nonce_hi_q, nonce_lo_q}),
		.slot    (item_slot_q),
		.stat    (gen_stat),
		.ks_word (ks_word)
	);

	// configuration writes; upper half of the 32-bit registers is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			nonce_lo_q   <= '0;
			nonce_hi_q   <= '0;
			init_count_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_0_7:    key_q[0]     <= cfg_data;
				REG_KEY_8_15:   key_q[1]     <= cfg_data;
				REG_KEY_16_23:  key_q[2]     <= cfg_data;
				REG_KEY_24_31:  key_q[3]     <= cfg_data;
				REG_NONCE_0_7:  nonce_lo_q   <= cfg_data;
				REG_NONCE_8_11: nonce_hi_q   <= cfg_data[31:0];
				REG_INIT_COUNT: init_count_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// sequencer and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			block_q     <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q <= slot_use + SLOT_W'(1);
						if (need_block) begin
							// advance the count once the block is started
							block_q <= block_use + 32'd1;
							state_q <= S_BUILD;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_BUILD: begin
					if (gen_stat.done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the beat; clamp counts above eight
	always_ff @(posedge clk) begin
		if (accept) begin
			item_text_q  <= text_word;
			item_count_q <= (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
			item_final_q <= final_word;
			item_slot_q  <= slot_use;
		end
	end

	// zero the bytes past the valid count
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			byte_mask[8 * b +: 8] = (4'(b) < item_count_q) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q  <= (item_text_q ^ ks_word) & byte_mask;
			out_bytes_q <= item_count_q;
			out_end_q   <= item_final_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_word    = out_word_q;
	assign result_bytes   = out_bytes_q;
	assign end_of_message = out_end_q;

`ifndef SYNTHESIS
	a_block_started: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (first_word || slot_q == '0) |=> gen_stat.busy)
		else $error("slot-zero beat did not start a keystream block");
	a_done_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		gen_stat.done |-> state_q == S_BUILD)
		else $error("keystream block finished outside build phase");
	a_out_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WAIT))
		else $error("result presented without a finished beat");
`endif

endmodule

`default_nettype wire
